/* rtl/core/topic_subscription_fanout_table_macros.svh */
// Assertion macros shared by the fan-out table modules
`ifndef TOPIC_SUBSCRIPTION_FANOUT_TABLE_MACROS_SVH
`define TOPIC_SUBSCRIPTION_FANOUT_TABLE_MACROS_SVH

// Implication checked on every edge outside reset
`define TSFT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsft check failed");

// Next-cycle implication outside reset
`define TSFT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsft check failed");

`endif

/* rtl/core/tsft_pkg.sv */
package tsft_pkg;

    localparam int TOPICS_DEF = 16;
    localparam int SUBS_DEF   = 16;

    localparam int ID_W   = 22;
    localparam int SLOT_W = 4;
    localparam int KIND_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACK     = 2'd0,
        KIND_DELIVER = 2'd1,
        KIND_REFUSE  = 2'd2
    } kind_t;

    localparam logic OP_PUBLISH   = 1'b0;
    localparam logic OP_SUBSCRIBE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_ACK,
        ST_READ,
        ST_WAIT,
        ST_DELIVER,
        ST_REFUSE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture request, clear search index
        logic step;        // advance search index
        logic create;      // create topic at next free slot
        logic append;      // append requester to matched slot
        logic rd_issue;    // read subscriber entry at fan-out index
        logic fan_next;    // advance fan-out index
        logic out_load;    // load output register
        kind_t kind;
        logic last;
        logic use_sub;     // target from subscriber memory
        logic slot_zero;   // report slot 0
    } tsft_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_sub;
        logic search_done;
        logic hit;
        logic table_full;
        logic list_full;
        logic count_zero;
        logic fan_last;
        logic out_busy;
    } tsft_stat_t;

endpackage

/* rtl/core/tsft_if.sv */
interface tsft_req_if;
    import tsft_pkg::*;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [63:0] topic_bytes_low;
    logic [63:0] topic_bytes_mid;
    logic [31:0] topic_bytes_high;
    logic [ID_W-1:0] requester_id;
    modport source (output valid, opcode, topic_bytes_low, topic_bytes_mid,
                    topic_bytes_high, requester_id, input ready);
    modport sink (input valid, opcode, topic_bytes_low, topic_bytes_mid,
                  topic_bytes_high, requester_id, output ready);
    // passive view for monitors
    modport monitor (input valid, ready, opcode, topic_bytes_low, topic_bytes_mid,
                     topic_bytes_high, requester_id);
endinterface

interface tsft_notice_if;
    import tsft_pkg::*;
    logic        valid;
    logic        ready;
    logic [KIND_W-1:0] notice_kind;
    logic [ID_W-1:0]   target_id;
    logic [SLOT_W-1:0] topic_slot;
    logic              last_notice;
    modport source (output valid, notice_kind, target_id, topic_slot, last_notice,
                    input ready);
    modport sink (input valid, notice_kind, target_id, topic_slot, last_notice,
                  output ready);
    // passive view for monitors
    modport monitor (input valid, ready, notice_kind, target_id, topic_slot,
                     last_notice);
endinterface

/* rtl/core/tsft_ctrl.sv */
module tsft_ctrl
    import tsft_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  tsft_stat_t stat,
    output tsft_cmd_t  cmd
);

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.kind   = KIND_ACK;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (stat.hit || stat.search_done)
                    state_next = ST_DECIDE;
                else
                    cmd.step = 1'b1;
            end
            ST_DECIDE:
            begin
                if (!stat.is_sub)
                begin
                    if (!stat.hit && !stat.table_full)
                        cmd.create = 1'b1;
                    state_next = ST_ACK;
                end
                else if (!stat.hit && stat.table_full)
                    state_next = ST_REFUSE;
                else if (!stat.hit)
                begin
                    // new topic becomes the hit, append on the next pass
                    cmd.create = 1'b1;
                    state_next = ST_DECIDE;
                end
                else if (stat.list_full)
                    state_next = ST_REFUSE;
                else
                begin
                    cmd.append = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_ACK:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.kind      = KIND_ACK;
                    cmd.slot_zero = !stat.hit && stat.table_full;
                    cmd.last      = !stat.hit || stat.count_zero;
                    state_next    = cmd.last ? ST_IDLE : ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_WAIT;
            end
            ST_WAIT:
                state_next = ST_DELIVER;
            ST_DELIVER:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    cmd.kind     = KIND_DELIVER;
                    cmd.use_sub  = 1'b1;
                    cmd.last     = stat.fan_last;
                    cmd.fan_next = 1'b1;
                    state_next   = stat.fan_last ? ST_IDLE : ST_READ;
                end
            end
            ST_REFUSE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.kind      = KIND_REFUSE;
                    cmd.slot_zero = !stat.hit;
                    cmd.last      = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

`include "topic_subscription_fanout_table_macros.svh"
    `TSFT_ASSERT_IMP(a_ready_idle, req_ready, state_reg == ST_IDLE)
    `TSFT_ASSERT_IMP(a_one_write, cmd.create, !cmd.append)
    `TSFT_ASSERT_NEXT(a_load_search, cmd.load, state_reg == ST_SEARCH)

endmodule

/* rtl/core/tsft_dp.sv */
module tsft_dp
    import tsft_pkg::*;
#(
    parameter int TOPICS = TOPICS_DEF,
    parameter int SUBS   = SUBS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    tsft_req_if.sink   req,
    tsft_notice_if.source notice,
    input  tsft_cmd_t  cmd,
    output tsft_stat_t stat
);

    localparam int TW = (TOPICS > 1) ? $clog2(TOPICS) : 1;
    localparam int SW = (SUBS > 1) ? $clog2(SUBS) : 1;
    localparam int CW = $clog2(SUBS + 1);
    localparam int UW = $clog2(TOPICS + 1);

    // name stores and subscriber memory
    logic [63:0] name_lo_mem [TOPICS];
    logic [63:0] name_mid_mem [TOPICS];
    logic [31:0] name_hi_mem [TOPICS];
    logic [ID_W-1:0] sub_mem [TOPICS*SUBS];
    logic [CW-1:0] count_reg [TOPICS];

    logic          op_reg;
    logic [63:0]   lo_reg, mid_reg;
    logic [31:0]   hi_reg;
    logic [ID_W-1:0] who_reg;
    logic [UW-1:0] used_reg;
    logic [UW-1:0] idx_reg;
    logic [SW-1:0] fan_reg;
    logic [ID_W-1:0] rd_reg;
    logic [63:0]   rlo_reg, rmid_reg;
    logic [31:0]   rhi_reg;
    logic          rvalid_reg;
    logic          hit_reg;

    logic          out_valid_reg;
    logic [KIND_W-1:0] out_kind_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic              out_last_reg;

    logic [TW-1:0] slot;
    logic [TW-1:0] rd_slot;
    logic [CW-1:0] cnt;
    logic          match;
    logic [TW+SW-1:0] sub_addr;

    assign slot    = idx_reg[TW-1:0];
    assign cnt     = count_reg[slot];
    assign match   = rvalid_reg && rlo_reg == lo_reg && rmid_reg == mid_reg
                     && rhi_reg == hi_reg;
    assign rd_slot = idx_reg[TW-1:0];

    // search index, hit flag, topic and subscriber counts, fan-out index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg   <= '0;
            idx_reg    <= '0;
            fan_reg    <= '0;
            rvalid_reg <= 1'b0;
            hit_reg    <= 1'b0;
            for (int i = 0; i < TOPICS; i++)
                count_reg[i] <= '0;
        end
        else
        begin
            // search pointer; a created topic becomes the current slot
            if (cmd.load)
                idx_reg <= '0;
            else if (cmd.step && !match)
                idx_reg <= idx_reg + 1'b1;
            else if (cmd.create)
                idx_reg <= used_reg;

            // stored name valid for compare next cycle
            if (cmd.load)
                rvalid_reg <= (used_reg != '0);
            else if (cmd.step && !match)
                rvalid_reg <= (idx_reg + 1'b1) < used_reg;
            else
                rvalid_reg <= 1'b0;

            // hit holds until the next request
            if (cmd.load)
                hit_reg <= 1'b0;
            else if (cmd.create || match)
                hit_reg <= 1'b1;

            if (cmd.create)
                used_reg <= used_reg + 1'b1;

            if (cmd.create)
                count_reg[used_reg[TW-1:0]] <= '0;
            else if (cmd.append)
                count_reg[slot] <= cnt + 1'b1;

            if (cmd.load)
                fan_reg <= '0;
            else if (cmd.fan_next)
                fan_reg <= fan_reg + 1'b1;
        end
    end

    // name store write and read, request capture
    always_ff @(posedge clk)
    begin
        if (cmd.create)
        begin
            name_lo_mem[used_reg[TW-1:0]]  <= lo_reg;
            name_mid_mem[used_reg[TW-1:0]] <= mid_reg;
            name_hi_mem[used_reg[TW-1:0]]  <= hi_reg;
        end
        rlo_reg  <= name_lo_mem[cmd.step ? rd_slot + 1'b1 : '0];
        rmid_reg <= name_mid_mem[cmd.step ? rd_slot + 1'b1 : '0];
        rhi_reg  <= name_hi_mem[cmd.step ? rd_slot + 1'b1 : '0];
        if (cmd.load)
        begin
            op_reg  <= req.opcode;
            lo_reg  <= req.topic_bytes_low;
            mid_reg <= req.topic_bytes_mid;
            hi_reg  <= req.topic_bytes_high;
            who_reg <= req.requester_id;
        end
    end

    // subscriber memory
    assign sub_addr = (TW+SW)'(slot) * (TW+SW)'(SUBS)
                      + (TW+SW)'(cmd.append ? cnt[SW-1:0] : fan_reg);
    always_ff @(posedge clk)
    begin
        if (cmd.append)
            sub_mem[sub_addr] <= who_reg;
        if (cmd.rd_issue)
            rd_reg <= sub_mem[sub_addr];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (notice.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_kind_reg <= cmd.kind;
            out_id_reg   <= cmd.use_sub ? rd_reg : who_reg;
            out_slot_reg <= cmd.slot_zero ? '0 : SLOT_W'(slot);
            out_last_reg <= cmd.last;
        end
    end

    assign notice.valid       = out_valid_reg;
    assign notice.notice_kind = out_kind_reg;
    assign notice.target_id   = out_id_reg;
    assign notice.topic_slot  = out_slot_reg;
    assign notice.last_notice = out_last_reg;

    // status
    assign stat.is_sub      = op_reg == OP_SUBSCRIBE;
    assign stat.search_done = !rvalid_reg && !hit_reg && !match;
    assign stat.hit         = hit_reg || match;
    assign stat.table_full  = used_reg == UW'(TOPICS);
    assign stat.list_full   = cnt == CW'(SUBS);
    assign stat.count_zero  = cnt == '0;
    assign stat.fan_last    = CW'(fan_reg) + 1'b1 == cnt;
    assign stat.out_busy    = out_valid_reg && !notice.ready;

`include "topic_subscription_fanout_table_macros.svh"
    `TSFT_ASSERT_IMP(a_used_range, 1'b1, used_reg <= UW'(TOPICS))
    `TSFT_ASSERT_IMP(a_create_free, cmd.create, used_reg < UW'(TOPICS))
    `TSFT_ASSERT_IMP(a_append_room, cmd.append, cnt < CW'(SUBS))

endmodule

/* rtl/core/topic_subscription_fanout_table.sv */
// Channel   Dir  Payload
// req       in   opcode, topic_bytes_low/mid/high, requester_id
// notice    out  notice_kind, target_id, topic_slot, last_notice
//
// A request searches one stored topic per cycle, then a publish emits its
// acknowledgement and then one delivery per subscriber, each read in turn
// from the single-port subscriber memory. One request is handled at a time.
// rst_n clears topic count and subscriber counts; name and id stores need no clear.
// A stalled notice holds in the output register and pauses the fan-out.
module topic_subscription_fanout_table
    import tsft_pkg::*;
#(
    parameter int TOPICS = TOPICS_DEF,
    parameter int SUBS   = SUBS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    tsft_req_if.sink      req,
    tsft_notice_if.source notice
);

    tsft_cmd_t  cmd;
    tsft_stat_t stat;

    tsft_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tsft_dp #(.TOPICS(TOPICS), .SUBS(SUBS)) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .notice (notice),
        .cmd    (cmd),
        .stat   (stat)
    );

endmodule
